@@ rtl/cihe_pkg.sv @@
// Shared types and constants for the CBOR item head encoder.
`default_nettype none

package cihe_pkg;

    // Operation codes on the request channel
    localparam logic [3:0] OP_UINT   = 4'd0;
    localparam logic [3:0] OP_SIGNED = 4'd1;
    localparam logic [3:0] OP_BYTES  = 4'd2;
    localparam logic [3:0] OP_TEXT   = 4'd3;
    localparam logic [3:0] OP_ARRAY  = 4'd4;
    localparam logic [3:0] OP_MAP    = 4'd5;
    localparam logic [3:0] OP_TAG    = 4'd6;
    localparam logic [3:0] OP_BREAK  = 4'd7;
    localparam logic [3:0] OP_BOOL   = 4'd8;
    localparam logic [3:0] OP_NULL   = 4'd9;
    localparam logic [3:0] OP_UNDEF  = 4'd10;
    localparam logic [3:0] OP_RAW    = 4'd11;

    // Major types
    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_BYTES = 3'd2;
    localparam logic [2:0] MT_TEXT  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;

    // Additional info codes for following argument bytes
    localparam logic [4:0] AI_INLINE_MAX = 5'd23;
    localparam logic [4:0] AI_ONE        = 5'd24;
    localparam logic [4:0] AI_TWO        = 5'd25;
    localparam logic [4:0] AI_FOUR       = 5'd26;
    localparam logic [4:0] AI_EIGHT      = 5'd27;

    // Fixed single-byte items
    localparam logic [7:0] BYTE_ARRAY_INDEF = 8'h9f;
    localparam logic [7:0] BYTE_MAP_INDEF   = 8'hbf;
    localparam logic [7:0] BYTE_BREAK       = 8'hff;
    localparam logic [7:0] BYTE_TRUE        = 8'hf5;
    localparam logic [7:0] BYTE_FALSE       = 8'hf4;
    localparam logic [7:0] BYTE_NULL        = 8'hf6;
    localparam logic [7:0] BYTE_UNDEF       = 8'hf7;

    localparam int unsigned MAX_EXTRA = 8;

    // One classified item: head byte, count of trailing bytes, and the
    // trailing bytes left-aligned so the next one sits in the top byte.
    typedef struct packed {
        logic [7:0]  lead;
        logic [3:0]  extra;
        logic [63:0] payload;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/cihe_req_if.sv @@
// Request channel: one CBOR item per transfer.
`default_nettype none

interface cihe_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic [63:0]        argument;
    logic signed [63:0] signed_argument;
    logic               indefinite;
    logic               truth;
    logic [7:0]         data_byte;

    modport source (
        output valid, operation, argument, signed_argument, indefinite, truth, data_byte,
        input  ready
    );

    modport sink (
        input  valid, operation, argument, signed_argument, indefinite, truth, data_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cihe_byte_if.sv @@
// Byte channel: one encoded byte per transfer with an end-of-item mark.
`default_nettype none

interface cihe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (
        output valid, out_byte, last,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cihe_front.sv @@
// Front end: accepts requests and classifies each into a head command.
`default_nettype none

module cihe_front (
    cihe_req_if.sink          req,
    output logic              push_valid,
    input  logic              push_ready,
    output cihe_pkg::cmd_t    push_cmd
);

    logic [2:0]  head_major;
    logic [63:0] head_arg;
    logic        use_head;
    logic [7:0]  single_byte;
    logic        known_op;
    logic [4:0]  ai;
    logic [3:0]  extra;
    logic [63:0] aligned;

    always_comb
    begin
        head_major  = cihe_pkg::MT_UINT;
        head_arg    = req.argument;
        use_head    = 1'b0;
        single_byte = req.data_byte;
        known_op    = 1'b1;
        case (req.operation)
            cihe_pkg::OP_UINT:
            begin
                use_head = 1'b1;
            end
            cihe_pkg::OP_SIGNED:
            begin
                use_head = 1'b1;
                // -1-n is the bitwise complement for negative values
                if (req.signed_argument[63])
                begin
                    head_major = cihe_pkg::MT_NINT;
                    head_arg   = ~req.signed_argument;
                end
                else
                begin
                    head_arg = req.signed_argument;
                end
            end
            cihe_pkg::OP_BYTES:
            begin
                use_head   = 1'b1;
                head_major = cihe_pkg::MT_BYTES;
            end
            cihe_pkg::OP_TEXT:
            begin
                use_head   = 1'b1;
                head_major = cihe_pkg::MT_TEXT;
            end
            cihe_pkg::OP_ARRAY:
            begin
                use_head    = !req.indefinite;
                head_major  = cihe_pkg::MT_ARRAY;
                single_byte = cihe_pkg::BYTE_ARRAY_INDEF;
            end
            cihe_pkg::OP_MAP:
            begin
                use_head    = !req.indefinite;
                head_major  = cihe_pkg::MT_MAP;
                single_byte = cihe_pkg::BYTE_MAP_INDEF;
            end
            cihe_pkg::OP_TAG:
            begin
                use_head   = 1'b1;
                head_major = cihe_pkg::MT_TAG;
            end
            cihe_pkg::OP_BREAK: single_byte = cihe_pkg::BYTE_BREAK;
            cihe_pkg::OP_BOOL:
            begin
                single_byte = req.truth ? cihe_pkg::BYTE_TRUE : cihe_pkg::BYTE_FALSE;
            end
            cihe_pkg::OP_NULL:  single_byte = cihe_pkg::BYTE_NULL;
            cihe_pkg::OP_UNDEF: single_byte = cihe_pkg::BYTE_UNDEF;
            cihe_pkg::OP_RAW:   single_byte = req.data_byte;
            default:            known_op    = 1'b0;
        endcase
    end

    // Pick the shortest argument form and left-align the trailing bytes
    always_comb
    begin
        if (head_arg[63:5] == '0 && head_arg[4:0] <= cihe_pkg::AI_INLINE_MAX)
        begin
            ai      = head_arg[4:0];
            extra   = 4'd0;
            aligned = '0;
        end
        else if (head_arg[63:8] == '0)
        begin
            ai      = cihe_pkg::AI_ONE;
            extra   = 4'd1;
            aligned = {head_arg[7:0], 56'd0};
        end
        else if (head_arg[63:16] == '0)
        begin
            ai      = cihe_pkg::AI_TWO;
            extra   = 4'd2;
            aligned = {head_arg[15:0], 48'd0};
        end
        else if (head_arg[63:32] == '0)
        begin
            ai      = cihe_pkg::AI_FOUR;
            extra   = 4'd4;
            aligned = {head_arg[31:0], 32'd0};
        end
        else
        begin
            ai      = cihe_pkg::AI_EIGHT;
            extra   = 4'(cihe_pkg::MAX_EXTRA);
            aligned = head_arg;
        end
    end

    always_comb
    begin
        if (use_head)
        begin
            push_cmd.lead    = {head_major, ai};
            push_cmd.extra   = extra;
            push_cmd.payload = aligned;
        end
        else
        begin
            push_cmd.lead    = single_byte;
            push_cmd.extra   = 4'd0;
            push_cmd.payload = '0;
        end
    end

    // Undefined codes are taken and dropped
    assign req.ready  = push_ready;
    assign push_valid = req.valid && known_op;

endmodule

`default_nettype wire

@@ rtl/cihe_queue.sv @@
// Command queue between the classifying front end and the byte sequencer.
`default_nettype none

module cihe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cihe_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output cihe_pkg::cmd_t out_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cihe_pkg::cmd_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

@@ rtl/cihe_back.sv @@
// Back end: turns queued head commands into a byte stream, one byte per cycle while rsp is ready.
`default_nettype none

module cihe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  cihe_pkg::cmd_t cmd,
    cihe_byte_if.source    rsp
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic [63:0] shift_reg;
    logic [63:0] shift_next;
    logic [3:0]  left_reg;
    logic [3:0]  left_next;
    logic        advance;

    // The output register may load whenever it is empty or being drained
    assign advance   = !out_valid_reg || rsp.ready;
    assign cmd_ready = advance && left_reg == '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        shift_next     = shift_reg;
        left_next      = left_reg;
        if (advance)
        begin
            if (left_reg != '0)
            begin
                // shift out the next argument byte, most significant first
                out_valid_next = 1'b1;
                out_byte_next  = shift_reg[63:56];
                out_last_next  = left_reg == 4'd1;
                shift_next     = {shift_reg[55:0], 8'd0};
                left_next      = left_reg - 1'b1;
            end
            else if (cmd_valid)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = cmd.lead;
                out_last_next  = cmd.extra == '0;
                shift_next     = cmd.payload;
                left_next      = cmd.extra;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        shift_reg    <= shift_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_byte = out_byte_reg;
    assign rsp.last     = out_last_reg;

`ifndef NO_ASSERTIONS
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 4'(cihe_pkg::MAX_EXTRA))
        else $error("too many argument bytes pending");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> left_reg == '0)
        else $error("last byte flagged with bytes still pending");

    a_pending_shown: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg != '0 |-> out_valid_reg && !out_last_reg)
        else $error("argument bytes pending without an open item");
`endif

endmodule

`default_nettype wire

@@ rtl/cbor_item_head_encoder_top.sv @@
// Top level of the CBOR item head encoder.
`default_nettype none

// Each request on req is one CBOR element; its encoding leaves on rsp one byte
// per transfer, with last set on the element's final byte. An element takes
// 1, 2, 3, 5 or 9 bytes: the byte-wide output register of the sequencer sets
// the rate, one byte per clock while rsp is ready, with no gap between queued
// elements. The first byte of a request is written into a queue slot and then
// into the sequencer's output register before it appears on rsp. Requests with
// undefined operation codes are accepted and produce nothing. QUEUE_DEPTH sets
// how many classified elements may wait between the front end and the sequencer.
module cbor_item_head_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    cihe_req_if.sink    req,
    cihe_byte_if.source rsp
);

    logic           push_valid;
    logic           push_ready;
    cihe_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    cihe_pkg::cmd_t pop_cmd;

    cihe_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    cihe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_cmd   (pop_cmd)
    );

    cihe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ verif/cihe_encoding_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts the CBOR byte stream for each request and compares it with the output.
module cihe_encoding_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic [3:0]         operation,
    input  logic [63:0]        argument,
    input  logic signed [63:0] signed_argument,
    input  logic               indefinite,
    input  logic               truth,
    input  logic [7:0]         data_byte,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic [7:0]         out_byte,
    input  logic               last,
    output int unsigned        error_count,
    output int unsigned        pending_bytes
);

    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } encoded_byte_t;

    encoded_byte_t expected_bytes[$];
    int unsigned   mismatches = 0;
    int unsigned   queued = 0;

    assign error_count   = mismatches;
    assign pending_bytes = queued;

    function automatic void push_byte(logic [7:0] octet, logic is_last);
        encoded_byte_t entry;
        entry.octet = octet;
        entry.last  = is_last;
        expected_bytes.push_back(entry);
    endfunction

    // Head byte, then the argument big-endian in the smallest of 0, 1, 2, 4 or 8 trailing bytes.
    function automatic void predict_head(logic [2:0] major, logic [63:0] value);
        logic [4:0] info;
        int         trail;
        int         k;
        if (value < 64'd24)
        begin
            info  = value[4:0];
            trail = 0;
        end
        else if (value < 64'd256)
        begin
            info  = cihe_pkg::AI_ONE;
            trail = 1;
        end
        else if (value < 64'd65536)
        begin
            info  = cihe_pkg::AI_TWO;
            trail = 2;
        end
        else if (value < 64'h1_0000_0000)
        begin
            info  = cihe_pkg::AI_FOUR;
            trail = 4;
        end
        else
        begin
            info  = cihe_pkg::AI_EIGHT;
            trail = 8;
        end
        push_byte({major, info}, trail == 0);
        for (k = trail - 1; k >= 0; k--)
            push_byte(value[8*k +: 8], k == 0);
    endfunction

    function automatic void predict_request(
        logic [3:0]         op,
        logic [63:0]        arg,
        logic signed [63:0] sarg,
        logic               indef,
        logic               flag,
        logic [7:0]         payload
    );
        case (op)
            cihe_pkg::OP_UINT:   predict_head(cihe_pkg::MT_UINT, arg);
            // negative values carry -1-n, which is the bitwise complement
            cihe_pkg::OP_SIGNED:
                if (sarg[63])
                    predict_head(cihe_pkg::MT_NINT, ~sarg);
                else
                    predict_head(cihe_pkg::MT_UINT, sarg);
            cihe_pkg::OP_BYTES:  predict_head(cihe_pkg::MT_BYTES, arg);
            cihe_pkg::OP_TEXT:   predict_head(cihe_pkg::MT_TEXT, arg);
            cihe_pkg::OP_ARRAY:
                if (indef)
                    push_byte(cihe_pkg::BYTE_ARRAY_INDEF, 1'b1);
                else
                    predict_head(cihe_pkg::MT_ARRAY, arg);
            cihe_pkg::OP_MAP:
                if (indef)
                    push_byte(cihe_pkg::BYTE_MAP_INDEF, 1'b1);
                else
                    predict_head(cihe_pkg::MT_MAP, arg);
            cihe_pkg::OP_TAG:    predict_head(cihe_pkg::MT_TAG, arg);
            cihe_pkg::OP_BREAK:  push_byte(cihe_pkg::BYTE_BREAK, 1'b1);
            cihe_pkg::OP_BOOL:
                push_byte(flag ? cihe_pkg::BYTE_TRUE : cihe_pkg::BYTE_FALSE, 1'b1);
            cihe_pkg::OP_NULL:   push_byte(cihe_pkg::BYTE_NULL, 1'b1);
            cihe_pkg::OP_UNDEF:  push_byte(cihe_pkg::BYTE_UNDEF, 1'b1);
            cihe_pkg::OP_RAW:    push_byte(payload, 1'b1);
            default:   ; // undefined codes are swallowed
        endcase
    endfunction

    function automatic void report_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        encoded_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
        end
        else
        begin
            // compare before predicting: a byte never leaves on its request's edge
            if (rsp_valid && rsp_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_error($sformatf("unexpected byte %02h last %0b",
                                           out_byte, last));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.octet || last !== want.last)
                        report_error($sformatf("byte %02h last %0b, expected %02h last %0b",
                                               out_byte, last, want.octet, want.last));
                end
            end
            if (req_valid && req_ready)
                predict_request(operation, argument, signed_argument, indefinite,
                                truth, data_byte);
        end
        queued = expected_bytes.size();
    end

endmodule

@@ verif/tb_cbor_item_head_encoder_top.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus, output back-pressure and the verdict.
module tb_cbor_item_head_encoder_top;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 46;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned PHASE_COUNT     = 4;

    logic        clk;
    logic        rst_n;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned cycle_count = 0;
    int unsigned error_count;
    int unsigned pending_bytes;

    // no idling, sender idle, receiver stalling, both
    int unsigned idle_by_phase[PHASE_COUNT]  = '{0, 64, 0, 29};
    int unsigned stall_by_phase[PHASE_COUNT] = '{0, 0, 64, 29};

    cihe_req_if  req_ch();
    cihe_byte_if rsp_ch();

    cbor_item_head_encoder_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cihe_encoding_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_ch.valid),
        .req_ready       (req_ch.ready),
        .operation       (req_ch.operation),
        .argument        (req_ch.argument),
        .signed_argument (req_ch.signed_argument),
        .indefinite      (req_ch.indefinite),
        .truth           (req_ch.truth),
        .data_byte       (req_ch.data_byte),
        .rsp_valid       (rsp_ch.valid),
        .rsp_ready       (rsp_ch.ready),
        .out_byte        (rsp_ch.out_byte),
        .last            (rsp_ch.last),
        .error_count     (error_count),
        .pending_bytes   (pending_bytes)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cbor_item_head_encoder_top regression: fail");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_request(
        logic [3:0]         op,
        logic [63:0]        arg,
        logic signed [63:0] sarg,
        logic               indef,
        logic               flag,
        logic [7:0]         payload
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.operation       = op;
        req_ch.argument        = arg;
        req_ch.signed_argument = sarg;
        req_ch.indefinite      = indef;
        req_ch.truth           = flag;
        req_ch.data_byte       = payload;
        req_ch.valid           = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted byte has left the block.
    task automatic wait_until_drained();
        req_ch.valid = 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
    endtask

    // Spread values over every argument width class and its boundaries.
    function automatic logic [63:0] pick_argument();
        logic [63:0] value;
        case ($urandom_range(5))
            0: value = 64'($urandom_range(23));
            1: value = 64'($urandom_range(255, 24));
            2: value = 64'($urandom_range(65535, 256));
            3: value = {32'd0, $urandom};
            4: value = {$urandom, $urandom};
            default:
                case ($urandom_range(8))
                    0: value = 64'd23;
                    1: value = 64'd24;
                    2: value = 64'd255;
                    3: value = 64'd256;
                    4: value = 64'd65535;
                    5: value = 64'd65536;
                    6: value = 64'hffff_ffff;
                    7: value = 64'h1_0000_0000;
                    default: value = '1;
                endcase
        endcase
        return value;
    endfunction

    task automatic send_random_request();
        logic [3:0]         op;
        logic [63:0]        arg;
        logic [63:0]        magnitude;
        logic signed [63:0] sarg;
        logic               indef;
        if ($urandom_range(99) < 5)
            op = 4'($urandom_range(15, 12));
        else
            op = 4'($urandom_range(11, 0));
        arg       = pick_argument();
        magnitude = pick_argument();
        sarg      = $urandom_range(1) ? ~magnitude : magnitude;
        indef     = ($urandom_range(99) < 30);
        send_request(op, arg, sarg, indef, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        int unsigned phase;
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.operation       = cihe_pkg::OP_UINT;
        req_ch.argument        = '0;
        req_ch.signed_argument = '0;
        req_ch.indefinite      = 1'b0;
        req_ch.truth           = 1'b0;
        req_ch.data_byte       = '0;
        sender_idle_pct        = 0;
        receiver_stall_pct     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // argument width boundaries
        send_request(cihe_pkg::OP_UINT, 64'd0, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, 64'd23, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, 64'd24, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, 64'd255, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, 64'd256, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, 64'd65536, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, 64'h1_0000_0000, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UINT, '1, '0, 1'b0, 1'b0, 8'h00);
        // minus one, most negative and most positive signed values
        send_request(cihe_pkg::OP_SIGNED, '0, -64'sd1, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_SIGNED, '0, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_SIGNED, '0, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_BYTES, 64'd24, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_TEXT, 64'd65535, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_ARRAY, 64'd4, '0, 1'b0, 1'b0, 8'h00);
        // indefinite starts ignore a large argument
        send_request(cihe_pkg::OP_ARRAY, '1, '1, 1'b1, 1'b1, 8'hff);
        send_request(cihe_pkg::OP_MAP, 64'h1_0000_0000, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_MAP, 64'd300, '0, 1'b1, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_TAG, 64'hffff_ffff, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_BREAK, '1, '1, 1'b1, 1'b1, 8'hff);
        send_request(cihe_pkg::OP_BOOL, '0, '0, 1'b0, 1'b1, 8'h00);
        send_request(cihe_pkg::OP_BOOL, '1, '1, 1'b1, 1'b0, 8'hff);
        send_request(cihe_pkg::OP_NULL, '0, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_UNDEF, '0, '0, 1'b0, 1'b0, 8'h00);
        send_request(cihe_pkg::OP_RAW, '1, '0, 1'b0, 1'b0, 8'ha5);
        send_request(4'd15, '1, '1, 1'b1, 1'b1, 8'hff);
        wait_until_drained();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            sender_idle_pct    = idle_by_phase[phase];
            receiver_stall_pct = stall_by_phase[phase];
            repeat (ITEMS_PER_PHASE) send_random_request();
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("cbor_item_head_encoder_top regression: pass");
        else
            $display("cbor_item_head_encoder_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cihe_pkg.sv
rtl/cihe_req_if.sv
rtl/cihe_byte_if.sv
rtl/cihe_front.sv
rtl/cihe_queue.sv
rtl/cihe_back.sv
rtl/cbor_item_head_encoder_top.sv
verif/cihe_encoding_checker.sv
verif/tb_cbor_item_head_encoder_top.sv
